// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/kbmrt_pkg.sv =====
// ---------------------------------------------------------------------------
// kbmrt_pkg
// Shared types and constants of the keyboard modifier / repeat tracker.
// ---------------------------------------------------------------------------
package kbmrt_pkg;

	localparam int NUM_KEYS_DEF = 512;

	localparam int KEY_W   = 9;
	localparam int DEV_W   = 8;
	localparam int MODS_W  = 12;
	localparam int TIME_W  = 16;
	localparam int ELAP_W  = 17;
	localparam int CIDX_W  = 4;

	localparam logic [KEY_W-1:0]  MOD_BASE   = 9'd300;
	localparam logic [KEY_W-1:0]  MOD_COUNT  = 9'd12;
	localparam logic [3:0]        LOCK_COUNT = 4'd3;
	localparam logic [ELAP_W-1:0] ELAP_MAX   = 17'h1FFFF;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_DELAY    = 4'd0;
	localparam logic [CIDX_W-1:0] CFG_INTERVAL = 4'd1;

	typedef enum logic [1:0] {
		OP_KEY      = 2'd0,
		OP_TICK     = 2'd1,
		OP_SET_MODS = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [KEY_W-1:0]  key_code;
		logic              pressed;
		logic [DEV_W-1:0]  source_device;
		logic [MODS_W-1:0] new_mods;
	} item_t;

	// tracker state other than the key table
	typedef struct packed {
		logic [MODS_W-1:0] mods;
		logic              rep_active;
		logic              rep_first;
		logic [ELAP_W-1:0] rep_elapsed;
		logic [KEY_W-1:0]  rep_key;
		logic [MODS_W-1:0] rep_mods;
		logic [DEV_W-1:0]  rep_device;
	} state_t;

	typedef struct packed {
		logic              event_valid;
		logic              event_is_repeat;
		logic              event_down;
		logic [DEV_W-1:0]  event_device;
		logic [KEY_W-1:0]  event_key;
		logic [MODS_W-1:0] event_mods;
		logic [MODS_W-1:0] current_mods;
		logic              key_is_down;
	} result_t;

	// key table update requested by one item
	typedef struct packed {
		logic en;
		logic data;
	} tbl_wr_t;

endpackage

// ===== hdl/kbmrt_ram.sv =====
// ---------------------------------------------------------------------------
// kbmrt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kbmrt_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = kbmrt_pkg::NUM_KEYS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/kbmrt_event_logic.sv =====
// ---------------------------------------------------------------------------
// kbmrt_event_logic
// Per-item decision logic: modifier mask, key table update, repeat slot.
// ---------------------------------------------------------------------------
module kbmrt_event_logic #(
	parameter int NUM_KEYS = kbmrt_pkg::NUM_KEYS_DEF
) (
	input  kbmrt_pkg::item_t                 item,
	input  logic                             stored_down,
	input  kbmrt_pkg::state_t                st,
	input  logic [kbmrt_pkg::TIME_W-1:0]     repeat_delay,
	input  logic [kbmrt_pkg::TIME_W-1:0]     repeat_interval,
	output kbmrt_pkg::state_t                st_nxt,
	output kbmrt_pkg::tbl_wr_t               tbl_wr,
	output kbmrt_pkg::result_t               res
);

	logic                            in_range;
	logic                            is_mod;
	logic                            is_lock;
	logic [kbmrt_pkg::KEY_W-1:0]     mod_off;
	logic [kbmrt_pkg::MODS_W-1:0]    mod_bit;
	logic [kbmrt_pkg::MODS_W-1:0]    newmod;
	logic [kbmrt_pkg::MODS_W-1:0]    evm;
	logic                            down_eff;
	logic                            arm;
	logic                            ignore_ev;
	logic                            changed;
	logic [kbmrt_pkg::ELAP_W-1:0]    elap_inc;

	always_comb begin
		in_range = ({23'd0, item.key_code} < 32'(NUM_KEYS));
		mod_off = item.key_code - kbmrt_pkg::MOD_BASE;
		is_mod  = (item.key_code >= kbmrt_pkg::MOD_BASE)
			&& (mod_off < kbmrt_pkg::MOD_COUNT);
		is_lock = is_mod && (mod_off[3:0] < kbmrt_pkg::LOCK_COUNT);
		mod_bit = is_mod ? (kbmrt_pkg::MODS_W'(1) << mod_off[3:0]) : '0;

		newmod    = st.mods;
		evm       = st.mods;
		down_eff  = item.pressed;
		arm       = 1'b0;
		ignore_ev = 1'b0;
		if (item.pressed) begin
			if (is_lock) begin
				newmod   = st.mods ^ mod_bit;
				down_eff = |(newmod & mod_bit);
				evm      = newmod;
			end else if (is_mod) begin
				newmod = st.mods | mod_bit;
			end else begin
				arm = 1'b1;
			end
		end else if (is_lock) begin
			ignore_ev = 1'b1;
		end else begin
			newmod = st.mods & ~mod_bit;
			evm    = newmod;
		end
		changed = !ignore_ev && (stored_down != down_eff);

		elap_inc = (st.rep_elapsed == kbmrt_pkg::ELAP_MAX)
			? st.rep_elapsed : st.rep_elapsed + 1'b1;

		st_nxt = st;
		tbl_wr = '0;
		res    = '0;

		unique case (item.op)
			kbmrt_pkg::OP_KEY: begin
				if (in_range && !ignore_ev) begin
					if (!down_eff && st.rep_active && st.rep_key == item.key_code) begin
						st_nxt.rep_active = 1'b0;
						st_nxt.rep_first  = 1'b0;
					end
					if (changed) begin
						tbl_wr.en   = 1'b1;
						tbl_wr.data = down_eff;
						st_nxt.mods = newmod;
						if (arm && repeat_delay != '0) begin
							st_nxt.rep_active  = 1'b1;
							st_nxt.rep_first   = 1'b1;
							st_nxt.rep_elapsed = '0;
							st_nxt.rep_key     = item.key_code;
							st_nxt.rep_mods    = evm;
							st_nxt.rep_device  = item.source_device;
						end
						if (item.source_device != '0) begin
							res.event_valid  = 1'b1;
							res.event_down   = down_eff;
							res.event_device = item.source_device;
							res.event_key    = item.key_code;
							res.event_mods   = evm;
						end
					end
				end
			end
			kbmrt_pkg::OP_TICK: begin
				if (st.rep_active) begin
					st_nxt.rep_elapsed = elap_inc;
					if (st.rep_first) begin
						if (elap_inc > {1'b0, repeat_delay}) begin
							st_nxt.rep_first   = 1'b0;
							st_nxt.rep_elapsed = '0;
						end
					end else if (elap_inc > {1'b0, repeat_interval}) begin
						st_nxt.rep_elapsed  = '0;
						res.event_valid     = 1'b1;
						res.event_is_repeat = 1'b1;
						res.event_down      = 1'b1;
						res.event_device    = st.rep_device;
						res.event_key       = st.rep_key;
						res.event_mods      = st.rep_mods;
					end
				end
			end
			kbmrt_pkg::OP_SET_MODS: begin
				st_nxt.mods = item.new_mods;
			end
			kbmrt_pkg::OP_QUERY: begin
				res.key_is_down = in_range && stored_down;
			end
			default: begin
				st_nxt = st;
			end
		endcase
		res.current_mods = st_nxt.mods;
	end

endmodule

// ===== hdl/keyboard_modifier_repeat_tracker_core.sv =====
// ---------------------------------------------------------------------------
// keyboard_modifier_repeat_tracker_core
// Key down table, modifier mask and typematic repeat slot on a stream.
// ---------------------------------------------------------------------------
// One word in, one word out. The block takes a word every cycle unless stalled
// by the output or the sweep: the word is registered in stage 1 together with
// its key table read, decided in one pass of logic and the result is then
// registered in the output register, from which it is offered.
// The output register lets the next word in while a result waits, so a full
// rate stream needs m_axis_tready high; stalls only pause the flow. The key
// table is one block RAM (NUM_KEYS x 1, one write and one registered read
// per cycle); a write made in the same cycle as the next word's read is
// forwarded, so back-to-back events on one key are exact. After reset the
// table is swept to zero, one entry a cycle; input ready stays low until
// the sweep ends, configuration writes are taken throughout.
// Registers (write only while the stream is idle): index 0 repeat delay,
// index 1 repeat interval, both in ms; writing either cancels a repeat.
// Other indexes are accepted and ignored.
module keyboard_modifier_repeat_tracker_core #(
	parameter int NUM_KEYS = kbmrt_pkg::NUM_KEYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [8:0] key_code, [9] pressed, [17:10] source_device, [29:18] new_mods
	input  logic [31:0] s_axis_tdata,
	// [1:0] op
	input  logic [1:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] event_down, [8:1] event_device, [17:9] event_key, [29:18] event_mods,
	// [41:30] current_mods, [42] key_is_down, rest zero
	output logic [47:0] m_axis_tdata,
	// [0] event_valid, [1] event_is_repeat
	output logic [1:0]  m_axis_tuser,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kbmrt_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [kbmrt_pkg::TIME_W-1:0]    cfg_data
);

	localparam int AW = $clog2(NUM_KEYS);

	// input word unpacked
	kbmrt_pkg::item_t in_item;
	assign in_item.op            = kbmrt_pkg::op_t'(s_axis_tuser);
	assign in_item.key_code      = s_axis_tdata[8:0];
	assign in_item.pressed       = s_axis_tdata[9];
	assign in_item.source_device = s_axis_tdata[17:10];
	assign in_item.new_mods      = s_axis_tdata[29:18];

	// clearing sweep after reset
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	// stage 1: registered word, RAM read data arrives alongside
	logic             v_s1;
	kbmrt_pkg::item_t item_s1;
	logic             lw_valid_s1;   // write made at this word's read edge
	logic [AW-1:0]    lw_addr_s1;
	logic             lw_data_s1;

	// output register
	logic               out_v_q;
	kbmrt_pkg::result_t out_q;

	// state and registers
	kbmrt_pkg::state_t          st_q;
	kbmrt_pkg::state_t          st_nxt;
	kbmrt_pkg::state_t          st_upd;
	logic [kbmrt_pkg::TIME_W-1:0] delay_q;
	logic [kbmrt_pkg::TIME_W-1:0] interval_q;

	kbmrt_pkg::tbl_wr_t tbl_wr;
	kbmrt_pkg::result_t res;

	logic          accept;
	logic          adv;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_rdata;
	logic          stored_down;
	logic          cfg_hit;

	// stage 1 moves on when the output register is free or being emptied
	assign adv           = v_s1 && (!out_v_q || m_axis_tready);
	assign s_axis_tready = !clearing_q && (!v_s1 || adv);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_hit       = cfg_valid && (cfg_index == kbmrt_pkg::CFG_DELAY
		|| cfg_index == kbmrt_pkg::CFG_INTERVAL);

	// table write port: sweep during clearing, else the retiring word
	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = adv && tbl_wr.en;
			ram_waddr = AW'(item_s1.key_code);
			ram_wdata = tbl_wr.data;
		end
	end

	kbmrt_ram #(
		.WIDTH(1),
		.DEPTH(NUM_KEYS)
	) u_key_tbl (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept),
		.raddr(AW'(in_item.key_code)),
		.rdata(ram_rdata)
	);

	// the write made while this word was read is not in the read data
	assign stored_down = (lw_valid_s1 && lw_addr_s1 == AW'(item_s1.key_code))
		? lw_data_s1 : ram_rdata;

	kbmrt_event_logic #(
		.NUM_KEYS(NUM_KEYS)
	) u_logic (
		.item           (item_s1),
		.stored_down    (stored_down),
		.st             (st_q),
		.repeat_delay   (delay_q),
		.repeat_interval(interval_q),
		.st_nxt         (st_nxt),
		.tbl_wr         (tbl_wr),
		.res            (res)
	);

	// clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(NUM_KEYS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			lw_valid_s1 <= 1'b0;
		end else if (accept) begin
			v_s1        <= 1'b1;
			lw_valid_s1 <= adv && tbl_wr.en;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= in_item;
			lw_addr_s1 <= AW'(item_s1.key_code);
			lw_data_s1 <= tbl_wr.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	// next tracker state; a register write cancels any repeat in progress
	always_comb begin
		st_upd = adv ? st_nxt : st_q;
		if (cfg_hit) begin
			st_upd.rep_active = 1'b0;
			st_upd.rep_first  = 1'b0;
		end
	end

	// tracker state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= '0;
			delay_q    <= '0;
			interval_q <= '0;
		end else begin
			st_q <= st_upd;
			if (cfg_valid && cfg_index == kbmrt_pkg::CFG_DELAY) begin
				delay_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == kbmrt_pkg::CFG_INTERVAL) begin
				interval_q <= cfg_data;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser  = {out_q.event_is_repeat, out_q.event_valid};
	assign m_axis_tdata  = {5'd0, out_q.key_is_down, out_q.current_mods,
		out_q.event_mods, out_q.event_key, out_q.event_device, out_q.event_down};

endmodule

// ===== hdl/kbmrt_checker.sv =====
// ---------------------------------------------------------------------------
// kbmrt_checker
// Port-level checks of the tracker core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kbmrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	logic stalled;
	assign stalled = m_axis_tvalid && !m_axis_tready;

	// a stalled result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_axis_tvalid)

	// and unchanged
	`ASSERT_NEXT(a_out_stable, clk, arst_n, stalled,
		$stable(m_axis_tdata) && $stable(m_axis_tuser))

	// a repeat is always a posted key-down event
	`ASSERT_IMPLIES(a_repeat_down, clk, arst_n, m_axis_tvalid && m_axis_tuser[1],
		m_axis_tuser[0] && m_axis_tdata[0])

	// with no event posted all event fields read zero
	`ASSERT_IMPLIES(a_no_event_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0],
		m_axis_tdata[29:0] == 30'd0 && !m_axis_tuser[1])

endmodule

bind keyboard_modifier_repeat_tracker_core kbmrt_checker u_kbmrt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
